// ----- sv/minimum_spanning_tree_weight_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the minimum spanning tree weight block
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_WEIGHT_TOP_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_WEIGHT_TOP_DEFINES_SVH

`ifndef SYNTH

`define MSTW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define MSTW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MSTW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define MSTW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- sv/mstw_pkg.sv -----
// ----------------------------------------------------------------------------
// mstw_pkg
// Shared types and constants of the minimum spanning tree weight block.
// ----------------------------------------------------------------------------
`default_nettype none

package mstw_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int END_BITS       = 7;
    localparam int CFG_BITS       = 7;
    localparam int IN_WEIGHT_BITS = 16;
    localparam int SUM_BITS       = 22;

    localparam logic [CFG_BITS-1:0] VC_RESET = 7'd64;

    typedef struct packed {
        logic [END_BITS-1:0]       end_a;
        logic [END_BITS-1:0]       end_b;
        logic [IN_WEIGHT_BITS-1:0] edge_weight;
        logic                      last;
    } t_in_word;

    typedef struct packed {
        logic [SUM_BITS-1:0] total_weight;
        logic                connected;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE,
        S_INIT,
        S_PASS,
        S_DRAIN,
        S_PICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_edge;
        logic write_edge;
        logic start_build;
        logic init_step;
        logic pass_step;
        logic take_best;
        logic finish;
        logic finish_conn;
        logic load_out;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic edge_last;
        logic k_last;
        logic n_one;
        logic best_vld;
        logic tree_full;
        logic out_free;
        logic clr_last;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/minimum_spanning_tree_weight_top.sv -----
// ----------------------------------------------------------------------------
// minimum_spanning_tree_weight_top
// Prim minimum spanning tree weight over an adjacency store of streamed edges.
// ----------------------------------------------------------------------------
// Edges enter one word per handshake on the input channel (valid/stall) and
// are kept in an edge memory, the lighter weight winning when a pair repeats.
// Each edge word goes through a read, compare, write of the edge memory, and
// the input stalls during the write. The word marked last starts the tree
// computation from vertex 1: the link memory is initialized, then up to
// n - 1 passes run, one vertex per cycle through the shared link memory port,
// and the result is handed to the output register. The total weight and
// the connected flag then appear as one word on the output channel.
// After each result, and after reset, the edge memory is swept clear, one
// entry per cycle, 2**(2*clog2(MAX_VERTICES)) entries (4096 by default);
// the input channel stalls during the sweep. The vertex count register is
// written on the configuration channel, which is always ready; reset sets it
// to 64. A stalled output word holds while the next graph loads; a second
// result waits until the first has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_spanning_tree_weight_top #(
    parameter int MAX_VERTICES = mstw_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mstw_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire mstw_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mstw_pkg::t_out_word                o_out_word,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mstw_pkg::CFG_BITS-1:0] i_cfg_data
);

    mstw_pkg::t_cmd cmd;
    mstw_pkg::t_sts sts;

    mstw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mstw_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// ----- sv/mstw_ctrl.sv -----
// ----------------------------------------------------------------------------
// mstw_ctrl
// Sequencer for edge loading, the tree passes, result hand-off and clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire mstw_pkg::t_sts i_sts,
    output mstw_pkg::t_cmd     o_cmd,
    output logic               o_in_stall
);

    mstw_pkg::t_state r_state;
    mstw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mstw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            mstw_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = mstw_pkg::S_IDLE;
                end
            end
            mstw_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_edge = 1'b1;
                    n_state         = mstw_pkg::S_EDGE;
                end
            end
            mstw_pkg::S_EDGE: begin
                o_cmd.write_edge = 1'b1;
                if (i_sts.edge_last) begin
                    o_cmd.start_build = 1'b1;
                    n_state           = mstw_pkg::S_INIT;
                end else begin
                    n_state = mstw_pkg::S_IDLE;
                end
            end
            mstw_pkg::S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.k_last) begin
                    if (i_sts.n_one) begin
                        o_cmd.finish      = 1'b1;
                        o_cmd.finish_conn = 1'b1;
                        n_state           = mstw_pkg::S_DONE;
                    end else begin
                        n_state = mstw_pkg::S_PASS;
                    end
                end
            end
            mstw_pkg::S_PASS: begin
                o_cmd.pass_step = 1'b1;
                if (i_sts.k_last) begin
                    n_state = mstw_pkg::S_DRAIN;
                end
            end
            mstw_pkg::S_DRAIN: begin
                n_state = mstw_pkg::S_PICK;
            end
            mstw_pkg::S_PICK: begin
                if (!i_sts.best_vld) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mstw_pkg::S_DONE;
                end else begin
                    o_cmd.take_best = 1'b1;
                    if (i_sts.tree_full) begin
                        o_cmd.finish      = 1'b1;
                        o_cmd.finish_conn = 1'b1;
                        n_state           = mstw_pkg::S_DONE;
                    end else begin
                        n_state = mstw_pkg::S_PASS;
                    end
                end
            end
            mstw_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mstw_pkg::S_CLEAR;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/mstw_dp.sv -----
// ----------------------------------------------------------------------------
// mstw_dp
// Edge store, per-vertex link memory, tree pass pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "minimum_spanning_tree_weight_top_defines.svh"

module mstw_dp #(
    parameter int MAX_VERTICES = mstw_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mstw_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mstw_pkg::t_in_word            i_in_word,
    input  wire logic                          i_cfg_valid,
    input  wire logic [mstw_pkg::CFG_BITS-1:0] i_cfg_data,
    output logic                               o_cfg_ready,
    output logic                               o_out_valid,
    output mstw_pkg::t_out_word                o_out_word,
    input  wire logic                          i_out_stall,
    input  wire mstw_pkg::t_cmd                i_cmd,
    output mstw_pkg::t_sts                     o_sts
);

    localparam int VB  = $clog2(MAX_VERTICES);
    localparam int NB  = $clog2(MAX_VERTICES + 1);
    localparam int SA  = 2 * VB;
    localparam int WB  = WEIGHT_BITS;
    localparam int CW1 = (NB > mstw_pkg::CFG_BITS) ? NB : mstw_pkg::CFG_BITS;
    localparam int CW  = (CW1 > mstw_pkg::END_BITS) ? CW1 : mstw_pkg::END_BITS;
    localparam int SB  = mstw_pkg::SUM_BITS;
    localparam int EB  = mstw_pkg::END_BITS;

    logic [WB:0]   r_store_mem [2**SA];
    logic [WB+1:0] r_link_mem  [2**VB];

    logic [mstw_pkg::CFG_BITS-1:0] r_vc;
    logic [SA-1:0]                 r_clr;
    logic [VB-1:0]                 r_k;
    logic                          r_wr_vld;
    logic                          r_best_vld;
    logic                          r_out_vld;

    logic [WB:0]   r_store_rd;
    logic [WB+1:0] r_link_rd;
    logic [NB-1:0] r_n;
    logic          r_eok;
    logic [SA-1:0] r_eaddr;
    logic [WB-1:0] r_ew;
    logic          r_elast;
    logic [VB-1:0] r_v;
    logic [VB-1:0] r_wr_k;
    logic [VB-1:0] r_best;
    logic [WB-1:0] r_best_w;
    logic [VB-1:0] r_edges;
    logic [SB-1:0] r_sum;
    logic          r_conn;
    mstw_pkg::t_out_word r_out;

    logic [NB-1:0] n_clamp;
    logic [EB-1:0] a_m1;
    logic [EB-1:0] b_m1;
    logic [VB-1:0] e_x;
    logic [VB-1:0] e_y;
    logic          e_ok;
    logic [SA-1:0] e_addr;
    logic [SA-1:0] p_addr;
    logic [NB-1:0] nm1_full;
    logic [VB-1:0] nm1;
    logic          edge_upd;
    logic          st_we;
    logic [SA-1:0] st_raddr;
    logic [SA-1:0] st_waddr;
    logic [WB:0]   st_wdata;
    logic          in_eff;
    logic          take;
    logic          new_has;
    logic [WB-1:0] new_w;
    logic          cand_better;
    logic          lk_we;
    logic [VB-1:0] lk_waddr;
    logic [WB+1:0] lk_wdata;
    logic          out_free;

    always_comb begin
        if (r_vc == '0) begin
            n_clamp = NB'(1);
        end else if (CW'(r_vc) > CW'(MAX_VERTICES)) begin
            n_clamp = NB'(MAX_VERTICES);
        end else begin
            n_clamp = NB'(r_vc);
        end
    end

    assign a_m1 = i_in_word.end_a - EB'(1);
    assign b_m1 = i_in_word.end_b - EB'(1);
    assign e_x  = VB'(a_m1);
    assign e_y  = VB'(b_m1);

    assign e_ok = (i_in_word.end_a != '0) && (CW'(i_in_word.end_a) <= CW'(n_clamp))
               && (i_in_word.end_b != '0) && (CW'(i_in_word.end_b) <= CW'(n_clamp))
               && (i_in_word.end_a != i_in_word.end_b);

    assign e_addr = (e_x < e_y) ? {e_x, e_y} : {e_y, e_x};
    assign p_addr = (r_v < r_k) ? {r_v, r_k} : {r_k, r_v};

    assign nm1_full = r_n - NB'(1);
    assign nm1      = VB'(nm1_full);

    assign edge_upd = r_eok && (!r_store_rd[WB] || (r_ew < r_store_rd[WB-1:0]));
    assign st_we    = i_cmd.clear_step || (i_cmd.write_edge && edge_upd);
    assign st_raddr = i_cmd.load_edge ? e_addr : p_addr;
    assign st_waddr = i_cmd.clear_step ? r_clr : r_eaddr;
    assign st_wdata = i_cmd.clear_step ? '0 : {1'b1, r_ew};

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store_mem[st_waddr] <= st_wdata;
        end
        r_store_rd <= r_store_mem[st_raddr];
    end

    always_comb begin
        in_eff  = r_link_rd[WB+1] || (r_wr_k == r_v);
        take    = !in_eff && r_store_rd[WB]
               && (!r_link_rd[WB] || (r_store_rd[WB-1:0] < r_link_rd[WB-1:0]));
        new_has = !in_eff && (r_link_rd[WB] || take);
        new_w   = take ? r_store_rd[WB-1:0] : r_link_rd[WB-1:0];
        cand_better = new_has && (!r_best_vld || (new_w < r_best_w));
    end

    assign lk_we    = i_cmd.init_step || r_wr_vld;
    assign lk_waddr = i_cmd.init_step ? r_k : r_wr_k;
    assign lk_wdata = i_cmd.init_step ? '0 : {in_eff, new_has, new_w};

    always_ff @(posedge i_clk) begin
        if (lk_we) begin
            r_link_mem[lk_waddr] <= lk_wdata;
        end
        r_link_rd <= r_link_mem[r_k];
    end

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc       <= mstw_pkg::VC_RESET;
            r_clr      <= '0;
            r_k        <= '0;
            r_wr_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_vc <= i_cfg_data;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + SA'(1);
            end
            if (i_cmd.start_build) begin
                r_k <= '0;
            end else if (i_cmd.init_step || i_cmd.pass_step) begin
                r_k <= (r_k == nm1) ? '0 : r_k + VB'(1);
            end
            r_wr_vld <= i_cmd.pass_step;
            if (i_cmd.start_build || i_cmd.take_best) begin
                r_best_vld <= 1'b0;
            end else if (r_wr_vld && cand_better) begin
                r_best_vld <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            r_n     <= n_clamp;
            r_eok   <= e_ok;
            r_eaddr <= e_addr;
            r_ew    <= WB'(i_in_word.edge_weight);
            r_elast <= i_in_word.last;
        end
        r_wr_k <= r_k;
        if (r_wr_vld && cand_better) begin
            r_best   <= r_wr_k;
            r_best_w <= new_w;
        end
        if (i_cmd.start_build) begin
            r_v     <= '0;
            r_edges <= '0;
            r_sum   <= '0;
        end else if (i_cmd.take_best) begin
            r_v     <= r_best;
            r_edges <= r_edges + VB'(1);
            r_sum   <= r_sum + SB'(r_best_w);
        end
        if (i_cmd.finish) begin
            r_conn <= i_cmd.finish_conn;
        end
        if (i_cmd.load_out) begin
            r_out.total_weight <= r_conn ? r_sum : '0;
            r_out.connected    <= r_conn;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.edge_last = r_elast;
        o_sts.k_last    = (r_k == nm1);
        o_sts.n_one     = (r_n == NB'(1));
        o_sts.best_vld  = r_best_vld;
        o_sts.tree_full = ((NB'(r_edges) + NB'(2)) == r_n);
        o_sts.out_free  = out_free;
        o_sts.clr_last  = (r_clr == '1);
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    `MSTW_ASSERT_IMP(a_link_port, i_clk, i_rst_n, r_wr_vld, !i_cmd.init_step, "link write collision")
    `MSTW_ASSERT_IMP(a_store_port, i_clk, i_rst_n, i_cmd.clear_step, !i_cmd.write_edge && !i_cmd.load_edge, "edge access during clear")
    `MSTW_ASSERT_IMP(a_out_load, i_clk, i_rst_n, i_cmd.load_out, out_free, "result overwritten")
    `MSTW_ASSERT_IMP(a_take_vld, i_clk, i_rst_n, i_cmd.take_best, r_best_vld, "vertex taken without a link")

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Minimum spanning tree weight testbench
// Streams graphs of weighted edges into the block and checks the tree weight
// and connected flag of every result word against a Prim predictor.
// The graphs run over many vertex counts, including the extreme counts.
// Random idling is applied on the edge input and the result output.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mstw_pkg::*;

    localparam int     MAX_V      = MAX_VERTICES_DEF;
    localparam int     ITEMS      = 1350;
    localparam int     MIN_TREES  = 40;
    localparam int     SWEEP_WAIT = 4200;
    localparam int     DRAIN_WAIT = 200;
    localparam longint LIMIT      = 3_000_000;

    class mst_scoreboard;
        bit                        has_edge [MAX_V][MAX_V];
        logic [IN_WEIGHT_BITS-1:0] edge_wt [MAX_V][MAX_V];
        logic [CFG_BITS-1:0]       count_reg;
        t_out_word                 tree_results_q[$];
        int                        errors;

        function new();
            count_reg = VC_RESET;
            errors = 0;
            clear_edges();
        endfunction

        function void clear_edges();
            foreach (has_edge[i, j]) begin
                has_edge[i][j] = 1'b0;
                edge_wt[i][j] = '0;
            end
        endfunction

        function void set_count(logic [CFG_BITS-1:0] v);
            count_reg = v;
        endfunction

        function int pending();
            return tree_results_q.size();
        endfunction

        function int live_count();
            if (count_reg == 0) begin
                return 1;
            end
            if (count_reg > MAX_V) begin
                return MAX_V;
            end
            return int'(count_reg);
        endfunction

        function t_out_word prim_tree_weight(int n);
            bit                        joined [MAX_V];
            bit                        reach [MAX_V];
            logic [IN_WEIGHT_BITS-1:0] link_wt [MAX_V];
            logic [SUM_BITS:0]         total;
            int                        taken;
            int                        v;
            int                        pick;
            bit                        ok;
            t_out_word                 r;
            foreach (joined[k]) begin
                joined[k] = 1'b0;
                reach[k] = 1'b0;
                link_wt[k] = '0;
            end
            total = '0;
            taken = 0;
            v = 0;
            ok = 1'b1;
            joined[0] = 1'b1;
            while (ok && taken + 1 < n) begin
                for (int k = 0; k < n; k++) begin
                    if (!joined[k] && has_edge[v][k] &&
                        (!reach[k] || edge_wt[v][k] < link_wt[k])) begin
                        reach[k] = 1'b1;
                        link_wt[k] = edge_wt[v][k];
                    end
                end
                pick = -1;
                for (int k = 0; k < n; k++) begin
                    if (!joined[k] && reach[k] && (pick < 0 || link_wt[k] < link_wt[pick])) begin
                        pick = k;
                    end
                end
                if (pick < 0) begin
                    ok = 1'b0;
                end else begin
                    joined[pick] = 1'b1;
                    total += link_wt[pick];
                    taken++;
                    v = pick;
                end
            end
            r.connected = ok;
            r.total_weight = ok ? total[SUM_BITS-1:0] : '0;
            return r;
        endfunction

        function void take_edge(t_in_word w);
            int n;
            int x;
            int y;
            n = live_count();
            x = int'(w.end_a) - 1;
            y = int'(w.end_b) - 1;
            if (x >= 0 && x < n && y >= 0 && y < n && x != y &&
                (!has_edge[x][y] || w.edge_weight < edge_wt[x][y])) begin
                has_edge[x][y] = 1'b1;
                has_edge[y][x] = 1'b1;
                edge_wt[x][y] = w.edge_weight;
                edge_wt[y][x] = w.edge_weight;
            end
            if (w.last) begin
                tree_results_q.push_back(prim_tree_weight(n));
                clear_edges();
            end
        endfunction

        function void check_tree(t_out_word got);
            t_out_word want;
            if (tree_results_q.size() == 0) begin
                errors++;
                $display("%0t: result word, expected none, actual total_weight %0d connected %0d",
                         $time, got.total_weight, got.connected);
                return;
            end
            want = tree_results_q.pop_front();
            if (got.total_weight !== want.total_weight) begin
                errors++;
                $display("%0t: total_weight expected %0d actual %0d",
                         $time, want.total_weight, got.total_weight);
            end
            if (got.connected !== want.connected) begin
                errors++;
                $display("%0t: connected expected %0d actual %0d",
                         $time, want.connected, got.connected);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_word            i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_word           o_out_word;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    mst_scoreboard sb = new();
    bit            calm = 1'b0;
    int            edge_items = 0;
    int            graphs = 0;
    longint        cycles = 0;

    minimum_spanning_tree_weight_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit gap_now();
        return !calm && ($urandom_range(99) < 14);
    endfunction

    function automatic t_in_word make_edge(int a, int b, int wt, bit fin);
        t_in_word w;
        w.end_a = END_BITS'(a);
        w.end_b = END_BITS'(b);
        w.edge_weight = IN_WEIGHT_BITS'(wt);
        w.last = fin;
        return w;
    endfunction

    function automatic int rand_weight(int style);
        case (style)
            0: return $urandom_range(65535, 0);
            1: return $urandom_range(7, 0);
            2: return 65535;
            default: return $urandom_range(1, 0) ? $urandom_range(65535, 0) : 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            sb.set_count(i_cfg_data);
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.take_edge(i_in_word);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_tree(o_out_word);
        end
        i_out_stall <= gap_now();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_edge(input t_in_word w);
        while (gap_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_trees_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_BITS-1:0] v);
        wait_trees_done();
        repeat (SWEEP_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_part();
        send_edge(make_edge(0, 0, 0, 0));
        send_edge(make_edge(127, 127, 65535, 0));
        send_edge(make_edge(5, 5, 1, 0));
        send_edge(make_edge(1, 2, 65535, 0));
        send_edge(make_edge(2, 1, 0, 0));
        send_edge(make_edge(1, 2, 100, 0));
        send_edge(make_edge(64, 1, 'h5555, 0));
        send_edge(make_edge(65, 1, 1, 0));
        send_edge(make_edge(1, 64, 'haaaa, 0));
        send_edge(make_edge(0, 0, 0, 1));
        write_count(0);
        send_edge(make_edge(1, 1, 5, 0));
        send_edge(make_edge(1, 2, 5, 0));
        send_edge(make_edge(0, 0, 65535, 1));
        write_count(2);
        send_edge(make_edge(2, 1, 65535, 1));
        send_edge(make_edge(2, 3, 9, 0));
        write_count(3);
        send_edge(make_edge(1, 2, 4, 0));
        send_edge(make_edge(3, 2, 6, 0));
        send_edge(make_edge(1, 3, 20, 1));
        write_count(127);
        send_edge(make_edge(64, 63, 65535, 0));
        send_edge(make_edge(1, 2, 3, 1));
    endtask

    task automatic random_graph();
        t_in_word items[$];
        int       perm[$];
        int       n;
        int       cfgv;
        int       style;
        int       r;
        int       drop;
        r = $urandom_range(99, 0);
        if (r < 55) begin
            n = $urandom_range(12, 2);
        end else if (r < 80) begin
            n = $urandom_range(40, 13);
        end else if (r < 92) begin
            n = MAX_V;
        end else begin
            n = 1;
        end
        cfgv = n;
        if (n == 1 && $urandom_range(1, 0)) begin
            cfgv = 0;
        end
        if (n == MAX_V && $urandom_range(1, 0)) begin
            cfgv = $urandom_range(127, MAX_V + 1);
        end
        write_count(CFG_BITS'(cfgv));
        style = $urandom_range(3, 0);
        for (int v = 1; v <= n; v++) begin
            perm.push_back(v);
        end
        perm.shuffle();
        drop = (n > 1 && $urandom_range(99, 0) < 15) ? $urandom_range(n - 1, 1) : 0;
        for (int v = 1; v < n; v++) begin
            if (v != drop) begin
                items.push_back(make_edge(perm[v], perm[$urandom_range(v - 1, 0)],
                                          rand_weight(style), 0));
            end
        end
        repeat ($urandom_range(n, 0)) begin
            items.push_back(make_edge($urandom_range(n, 1), $urandom_range(n, 1),
                                      rand_weight(style), 0));
        end
        edge_items += items.size();
        repeat ($urandom_range(2, 0)) begin
            items.push_back(make_edge($urandom_range(1, 0) ? $urandom_range(127, n + 1) : 0,
                                      $urandom_range(127, 0), $urandom(), 0));
        end
        items.shuffle();
        if (items.size() == 0 || $urandom_range(4, 0) == 0) begin
            items.push_back(make_edge(0, $urandom_range(127, 0), $urandom(), 1));
        end else begin
            items[items.size() - 1].last = 1'b1;
        end
        foreach (items[i]) begin
            send_edge(items[i]);
        end
        graphs++;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_part();
        while (edge_items < ITEMS || graphs < MIN_TREES) begin
            calm = (graphs >= 8 && graphs < 14);
            random_graph();
        end
        calm = 1'b0;
        wait_trees_done();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
